/* rtl/core/escc_pkg.sv */
`default_nettype none
package escc_pkg;

  // Reciprocal multipliers: floor(x / D) == (x * M) >> K over each operand range used
  localparam logic [25:0] M675     = 26'd50903317;  // K = 35, x < 2^25
  localparam int          K675     = 35;
  localparam logic [16:0] M1461    = 17'd91868;     // K = 27, x < 50383
  localparam int          K1461    = 27;
  localparam logic [10:0] M365     = 11'd1437;      // K = 19, x < 1461
  localparam int          K365     = 19;
  localparam logic [16:0] M7       = 17'd74899;     // K = 19, x < 2^16
  localparam int          K7       = 19;
  localparam logic [17:0] M60_SEC  = 18'd139811;    // K = 23, x < 86400
  localparam int          K60_SEC  = 23;
  localparam logic [11:0] M60_MIN  = 12'd2185;      // K = 17, x < 1440
  localparam int          K60_MIN  = 17;

  localparam int SEC_SHIFT   = 7;      // 86400 = 675 << 7
  localparam int DAY_CORE    = 675;
  localparam int SECS_DAY    = 86400;
  localparam int CYCLE_DAYS  = 1461;   // four-year cycle
  localparam int YEAR_DAYS   = 365;
  localparam int BASE_YEAR   = 1968;   // day count runs from 1968-03-01
  localparam int BASE_OFFSET = 671;    // 1968-03-01 .. 1970-01-01
  localparam int SKIP_DAY    = 48212;  // 2100-03-01: no leap day in 2100
  localparam int YEAR_LOW    = 1970;
  localparam int YEAR_HIGH   = 2099;

  typedef struct packed {
    logic        kind;
    logic [24:0] x;       // seconds >> 7
    logic [6:0]  lo7;
    logic [15:0] days0;
    logic [16:0] sod;     // second of day
    logic [15:0] dp;      // day count from 1968-03-01, 2100 skip applied
    logic [5:0]  q4;
    logic [10:0] r4;
    logic [1:0]  yr;
    logic [8:0]  doy;
    logic [11:0] ybase;
    logic [10:0] mq;      // minute of day
    logic [4:0]  hq;
    logic [5:0]  sec;
    logic [5:0]  mins;
    logic        ok;
    logic [7:0]  t;       // March-based years since 1968
    logic [8:0]  doy1;
    logic [16:0] hms;
    logic [15:0] days1;
    logic [31:0] secs1;
    logic [16:0] w;
    logic [14:0] pw;
    logic [2:0]  wd;
  } escc_item_t;

  // Day of a March-based year on which month index mm starts (0 = March)
  function automatic logic [8:0] month_start(input logic [3:0] mm);
    logic [8:0] r;
    case (mm)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Longest length of month idx (0 = January), February allowing 29
  function automatic logic [4:0] month_len(input logic [3:0] idx);
    logic [4:0] r;
    case (idx)
      4'd0:    r = 5'd31;
      4'd1:    r = 5'd29;
      4'd2:    r = 5'd31;
      4'd3:    r = 5'd30;
      4'd4:    r = 5'd31;
      4'd5:    r = 5'd30;
      4'd6:    r = 5'd31;
      4'd7:    r = 5'd31;
      4'd8:    r = 5'd30;
      4'd9:    r = 5'd31;
      4'd10:   r = 5'd30;
      4'd11:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/epoch_seconds_civil_date_converter_top.sv */
`default_nettype none
// Epoch seconds <-> civil date converter, seven-stage pipeline.
// A result strobes on done once the item has passed stage registers s1 to s6 and the output registers.
// Throughput: one item per cycle; busy is always low, since every stage advances
// each cycle and the receiver cannot stall.
// Reset (rst, synchronous): clears the stage valid bits and done; items in flight
// are dropped. Payload registers are not reset.
module epoch_seconds_civil_date_converter_top
  import escc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind,
  input  wire logic [31:0] epoch_seconds,
  input  wire logic [15:0] in_year,
  input  wire logic [7:0]  in_month,
  input  wire logic [7:0]  in_day,
  input  wire logic [7:0]  in_hour,
  input  wire logic [7:0]  in_minute,
  input  wire logic [7:0]  in_second,
  output logic             done,
  output logic [31:0]      out_seconds,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic [2:0]       weekday,
  output logic             valid_res
);

  // Stage registers and their valid bits
  escc_item_t s1, s2, s3, s4, s5, s6;
  escc_item_t s1_next, s2_next, s3_next, s4_next, s5_next, s6_next;
  logic       v1, v2, v3, v4, v5, v6;

  assign busy = 1'b0;

  // Stage 1: seconds -> day count (reciprocal multiply of seconds >> 7 by 1/675);
  // civil input check, March-based year and day of year, second of day.
  logic [50:0] p_day;
  logic        febjan;
  logic [15:0] y_adj;
  logic [3:0]  mm;
  logic [4:0]  mlen;
  logic        chk_year, chk_month, chk_day, chk_leap, chk_time;

  always_comb begin
    s1_next       = '0;
    s1_next.kind  = kind;
    s1_next.x     = epoch_seconds[31:SEC_SHIFT];
    s1_next.lo7   = epoch_seconds[SEC_SHIFT-1:0];
    p_day         = 51'(epoch_seconds[31:SEC_SHIFT]) * 51'(M675);
    s1_next.days0 = p_day[K675 +: 16];

    chk_year  = (in_year >= 16'(YEAR_LOW)) && (in_year <= 16'(YEAR_HIGH));
    chk_month = (in_month >= 8'd1) && (in_month <= 8'd12);
    mlen      = month_len(4'(in_month[3:0] - 4'd1));
    chk_day   = chk_month && (in_day >= 8'd1) && (in_day <= 8'(mlen));
    // 29 February only in years divisible by four
    chk_leap  = !((in_month == 8'd2) && (in_day == 8'd29) && (in_year[1:0] != 2'd0));
    chk_time  = (in_hour < 8'd24) && (in_minute < 8'd60) && (in_second < 8'd60);
    s1_next.ok = chk_year && chk_month && chk_day && chk_leap && chk_time;

    febjan       = (in_month <= 8'd2);
    y_adj        = in_year - 16'(febjan);
    s1_next.t    = 8'(y_adj - 16'(BASE_YEAR));
    mm           = febjan ? 4'(in_month[3:0] + 4'd9) : 4'(in_month[3:0] - 4'd3);
    s1_next.doy1 = 9'(month_start(mm) + 9'(in_day[4:0]) - 9'd1);
    s1_next.hms  = 17'(17'(in_hour[4:0]) * 17'd3600 + 17'(in_minute[5:0]) * 17'd60
                   + 17'(in_second[5:0]));
  end

  // Stage 2: second of day; shifted day count with 2100 correction; civil day count.
  logic [24:0] rem_x;
  logic [16:0] d_raw;
  logic [16:0] d_civ;

  always_comb begin
    s2_next     = s1;
    rem_x       = s1.x - 25'(s1.days0 * 25'(DAY_CORE));
    s2_next.sod = {rem_x[9:0], s1.lo7};
    d_raw       = 17'(s1.days0) + 17'(BASE_OFFSET);
    s2_next.dp  = 16'(d_raw + 17'(d_raw >= 17'(SKIP_DAY)));
    d_civ       = 17'(s1.t) * 17'(YEAR_DAYS) + 17'(s1.t[7:2]) + 17'(s1.doy1)
                  - 17'(BASE_OFFSET);
    s2_next.days1 = d_civ[15:0];
  end

  // Stage 3: four-year cycle quotient, minute of day, weekday quotient, civil seconds.
  logic [32:0] p_cyc;
  logic [34:0] p_min;
  logic [33:0] p_wk;
  logic [15:0] dd;

  always_comb begin
    s3_next       = s2;
    p_cyc         = 33'(s2.dp) * 33'(M1461);
    s3_next.q4    = p_cyc[K1461 +: 6];
    p_min         = 35'(s2.sod) * 35'(M60_SEC);
    s3_next.mq    = p_min[K60_SEC +: 11];
    dd            = s2.kind ? s2.days1 : s2.days0;
    s3_next.w     = 17'(dd) + 17'd4;
    p_wk          = 34'(s3_next.w) * 34'(M7);
    s3_next.pw    = p_wk[K7 +: 15];
    s3_next.secs1 = 32'(32'(s2.days1) * 32'(SECS_DAY)) + 32'(s2.hms);
  end

  // Stage 4: day within cycle, second, hour, weekday.
  logic [15:0] cyc_base;
  logic [16:0] min_base;
  logic [16:0] wk_base;
  logic [22:0] p_hr;

  always_comb begin
    s4_next     = s3;
    cyc_base    = 16'(s3.q4 * 16'(CYCLE_DAYS));
    s4_next.r4  = 11'(s3.dp - cyc_base);
    min_base    = 17'(s3.mq * 17'd60);
    s4_next.sec = 6'(s3.sod - min_base);
    p_hr        = 23'(s3.mq) * 23'(M60_MIN);
    s4_next.hq  = p_hr[K60_MIN +: 5];
    wk_base     = 17'(s3.pw * 17'd7);
    s4_next.wd  = 3'(s3.w - wk_base);
  end

  // Stage 5: year within cycle (the last day of a cycle stays in year three), minute.
  logic [21:0] p_yr;
  logic [2:0]  yq;
  logic [10:0] hr_base;

  always_comb begin
    s5_next      = s4;
    p_yr         = 22'(s4.r4) * 22'(M365);
    yq           = p_yr[K365 +: 3];
    s5_next.yr   = (yq > 3'd3) ? 2'd3 : yq[1:0];
    hr_base      = 11'(s4.hq * 11'd60);
    s5_next.mins = 6'(s4.mq - hr_base);
  end

  // Stage 6: March-based day of year and year.
  always_comb begin
    s6_next       = s5;
    s6_next.doy   = 9'(s5.r4 - 11'(s5.yr * 11'(YEAR_DAYS)));
    s6_next.ybase = 12'(12'(BASE_YEAR) + {4'd0, s5.q4, 2'd0} + 12'(s5.yr));
  end

  // Output stage: month from month-start compares, then pick fields by kind.
  logic [3:0]  mp;
  logic [3:0]  m_civ;
  logic [4:0]  d_out;
  logic [11:0] y_out;

  always_comb begin
    mp = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (s6.doy >= month_start(4'(i))) begin
        mp = 4'(i);
      end
    end
    d_out = 5'(s6.doy - month_start(mp) + 9'd1);
    m_civ = (mp < 4'd10) ? 4'(mp + 4'd3) : 4'(mp - 4'd9);
    y_out = s6.ybase + 12'(mp >= 4'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      v6   <= v5;
      done <= v6;
    end
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
    s2 <= s2_next;
    s3 <= s3_next;
    s4 <= s4_next;
    s5 <= s5_next;
    s6 <= s6_next;
    if (!s6.kind) begin
      out_seconds <= '0;
      out_year    <= y_out;
      out_month   <= m_civ;
      out_day     <= d_out;
      out_hour    <= s6.hq;
      out_minute  <= s6.mins;
      out_second  <= s6.sec;
      weekday     <= s6.wd;
      valid_res   <= 1'b1;
    end else begin
      // civil to seconds: only seconds and weekday, and only if the check passed
      out_seconds <= s6.ok ? s6.secs1 : '0;
      out_year    <= '0;
      out_month   <= '0;
      out_day     <= '0;
      out_hour    <= '0;
      out_minute  <= '0;
      out_second  <= '0;
      weekday     <= s6.ok ? s6.wd : '0;
      valid_res   <= s6.ok;
    end
  end

endmodule
`default_nettype wire
